// ===== sv/xave_pkg.sv =====
// ----------------------------------------------------------------------------
// xave_pkg
// Shared constants for the XML attribute value extractor and its checker.
// ----------------------------------------------------------------------------
package xave_pkg;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;

	localparam logic [3:0] NAME_CHARS  = 4'd8;
	localparam logic [3:0] MATCH_CHARS = 4'd8;
	localparam logic [3:0] TRUE_LEN    = 4'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_ATTR_NAME     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ATTR_NAME_LEN = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RESULT_MODE   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MATCH_TEXT    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MATCH_LEN     = 3'd4;

	localparam logic [1:0] MODE_BYTES   = 2'd0;
	localparam logic [1:0] MODE_INTEGER = 2'd1;
	localparam logic [1:0] MODE_TRUE    = 2'd2;
	localparam logic [1:0] MODE_MATCH   = 2'd3;

	localparam logic [7:0] CHR_QUOTE = 8'd34;
	localparam logic [7:0] CHR_SPACE = 8'd32;
	localparam logic [7:0] CHR_EQUAL = 8'd61;
	localparam logic [7:0] CHR_PLUS  = 8'd43;
	localparam logic [7:0] CHR_MINUS = 8'd45;
	localparam logic [7:0] CHR_ZERO  = 8'd48;
	localparam logic [7:0] CHR_NINE  = 8'd57;
	localparam logic [7:0] CHR_TAB   = 8'd9;
	localparam logic [7:0] CHR_CR    = 8'd13;

	localparam logic [31:0] TRUE_TEXT = 32'h65757274;

	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

endpackage

// ===== sv/xml_attribute_value_extractor.sv =====
// ----------------------------------------------------------------------------
// xml_attribute_value_extractor
// Finds a configured attribute in streamed XML text and reports its value.
// ----------------------------------------------------------------------------
// Text enters on the s_axis channel one byte per word; s_axis_tlast marks the
// last byte of a text, and a zero byte also ends it. Results leave on the
// m_axis channel: in byte mode each value byte gives one word, and the end of
// every text gives one final word with m_axis_tlast high carrying the found
// flag and the answer. Bytes that yield no result are absorbed silently.
// The user must write the configuration port only while the block is idle;
// the block does not enforce this. Each byte passes an input register, the state
// update logic and the result register before its result word is offered.
// One byte is accepted in every cycle while no stall holds the result register;
// that register sets this, since a byte moves on once it is empty or being emptied.
// When the receiver holds m_axis_tready low the result register and then the
// input register fill and s_axis_tready falls; nothing is dropped.
// Reset clears the text state, the valid flags and the result and configuration
// registers, with the name length set to one; the input byte is not reset.
// ----------------------------------------------------------------------------
module xml_attribute_value_extractor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [xave_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // data_byte
	input  logic                                s_axis_tlast,  // end_of_text
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// value_byte[7:0], value_byte_valid[8], found[9], answer[41:10], zero fill
	output logic [xave_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tlast,  // finished
	input  logic                                cfg_we,
	input  logic [xave_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [xave_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		PH_SEEK, PH_NAME, PH_SKIP, PH_VALUE, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		NUM_WS, NUM_DIGITS, NUM_STOP
	} num_phase_t;

	logic [63:0] attr_name_q;
	logic [3:0]  attr_name_len_q;
	logic [1:0]  result_mode_q;
	logic [63:0] match_text_q;
	logic [3:0]  match_len_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;

	phase_t      phase_q, phase_d;
	logic [3:0]  name_pos_q, name_pos_d;
	logic [31:0] acc_q, acc_d;
	num_phase_t  num_q, num_d;
	logic        neg_q, neg_d;
	logic [3:0]  cmp_pos_q, cmp_pos_d;
	logic        cmp_eq_q, cmp_eq_d;
	logic        found_q, found_d;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_byte_valid_q;
	logic        out_found_q;
	logic [31:0] out_answer_q;
	logic        out_last_q;

	logic        out_free;
	logic        advance;
	logic        ends;
	logic        emit;
	logic [3:0]  name_len;
	logic [3:0]  ref_len;
	logic [7:0]  ref_chr;
	logic [7:0]  name_chr;
	logic        is_ws;
	logic        is_digit;
	logic        to_digits;
	logic [35:0] acc_mul;
	logic [31:0] answer;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign ends = eot_s1 || (byte_s1 == 8'd0);

	assign name_len = (attr_name_len_q > xave_pkg::NAME_CHARS) ?
		xave_pkg::NAME_CHARS : attr_name_len_q;
	assign name_chr = attr_name_q[{name_pos_q[2:0], 3'b000} +: 8];

	always_comb begin
		if (result_mode_q == xave_pkg::MODE_TRUE) begin
			ref_len = xave_pkg::TRUE_LEN;
			ref_chr = xave_pkg::TRUE_TEXT[{cmp_pos_q[1:0], 3'b000} +: 8];
		end else begin
			ref_len = (match_len_q > xave_pkg::MATCH_CHARS) ?
				xave_pkg::MATCH_CHARS : match_len_q;
			ref_chr = match_text_q[{cmp_pos_q[2:0], 3'b000} +: 8];
		end
	end

	assign is_ws    = (byte_s1 == xave_pkg::CHR_SPACE) ||
		((byte_s1 >= xave_pkg::CHR_TAB) && (byte_s1 <= xave_pkg::CHR_CR));
	assign is_digit = (byte_s1 >= xave_pkg::CHR_ZERO) && (byte_s1 <= xave_pkg::CHR_NINE);
	assign acc_mul  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
		{32'd0, byte_s1[3:0] - xave_pkg::CHR_ZERO[3:0]};

	always_comb begin
		phase_d   = phase_q;
		name_pos_d = name_pos_q;
		acc_d     = acc_q;
		num_d     = num_q;
		neg_d     = neg_q;
		cmp_pos_d = cmp_pos_q;
		cmp_eq_d  = cmp_eq_q;
		found_d   = found_q;
		emit      = 1'b0;
		to_digits = 1'b0;
		if (byte_s1 != 8'd0) begin
			case (phase_q)
				PH_SEEK: begin
					if (byte_s1 == xave_pkg::CHR_SPACE) begin
						phase_d    = PH_NAME;
						name_pos_d = 4'd0;
					end
				end
				PH_NAME: begin
					if ((name_pos_q < name_len) && (byte_s1 == name_chr)) begin
						name_pos_d = name_pos_q + 4'd1;
					end else if ((name_pos_q >= name_len) &&
						(byte_s1 == xave_pkg::CHR_EQUAL)) begin
						found_d = 1'b1;
						phase_d = PH_SKIP;
					end else if (byte_s1 == xave_pkg::CHR_SPACE) begin
						name_pos_d = 4'd0;
					end else begin
						phase_d    = PH_SEEK;
						name_pos_d = 4'd0;
					end
				end
				PH_SKIP: begin
					phase_d = PH_VALUE;
				end
				PH_VALUE: begin
					if (byte_s1 == xave_pkg::CHR_QUOTE) begin
						phase_d = PH_DONE;
					end else begin
						emit = (result_mode_q == xave_pkg::MODE_BYTES);
						if (num_q == NUM_WS) begin
							if (!is_ws) begin
								num_d = NUM_DIGITS;
								if ((byte_s1 == xave_pkg::CHR_PLUS) ||
									(byte_s1 == xave_pkg::CHR_MINUS)) begin
									neg_d = (byte_s1 == xave_pkg::CHR_MINUS);
								end else begin
									to_digits = 1'b1;
								end
							end
						end else if (num_q == NUM_DIGITS) begin
							to_digits = 1'b1;
						end
						if (to_digits) begin
							if (is_digit) begin
								acc_d = (acc_mul > {4'd0, xave_pkg::MAG_LIMIT}) ?
									xave_pkg::MAG_LIMIT : acc_mul[31:0];
							end else begin
								num_d = NUM_STOP;
							end
						end
						if ((cmp_pos_q < ref_len) && (byte_s1 == ref_chr)) begin
							cmp_pos_d = cmp_pos_q + 4'd1;
						end else begin
							cmp_eq_d = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		answer = 32'd0;
		if (found_d) begin
			case (result_mode_q)
				xave_pkg::MODE_INTEGER: begin
					if (neg_d) begin
						answer = 32'd0 - acc_d;
					end else begin
						answer = (acc_d > xave_pkg::POS_LIMIT) ? xave_pkg::POS_LIMIT : acc_d;
					end
				end
				xave_pkg::MODE_TRUE, xave_pkg::MODE_MATCH: begin
					answer = {31'd0, cmp_eq_d && (cmp_pos_d == ref_len)};
				end
				default: begin
					answer = 32'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_name_q     <= '0;
			attr_name_len_q <= 4'd1;
			result_mode_q   <= xave_pkg::MODE_BYTES;
			match_text_q    <= '0;
			match_len_q     <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				xave_pkg::REG_ATTR_NAME:     attr_name_q     <= cfg_data;
				xave_pkg::REG_ATTR_NAME_LEN: attr_name_len_q <= cfg_data[3:0];
				xave_pkg::REG_RESULT_MODE:   result_mode_q   <= cfg_data[1:0];
				xave_pkg::REG_MATCH_TEXT:    match_text_q    <= cfg_data;
				xave_pkg::REG_MATCH_LEN:     match_len_q     <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eot_s1  <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_SEEK;
			name_pos_q       <= 4'd0;
			acc_q            <= 32'd0;
			num_q            <= NUM_WS;
			neg_q            <= 1'b0;
			cmp_pos_q        <= 4'd0;
			cmp_eq_q         <= 1'b1;
			found_q          <= 1'b0;
			out_valid_q      <= 1'b0;
			out_byte_q       <= 8'd0;
			out_byte_valid_q <= 1'b0;
			out_last_q       <= 1'b0;
			out_found_q      <= 1'b0;
			out_answer_q     <= 32'd0;
		end else begin
			if (out_free) begin
				out_valid_q <= advance && (ends || emit);
			end
			if (advance) begin
				out_byte_q       <= emit ? byte_s1 : 8'd0;
				out_byte_valid_q <= emit;
				out_last_q       <= ends;
				out_found_q      <= ends && found_d;
				out_answer_q     <= ends ? answer : 32'd0;
				if (ends) begin
					phase_q    <= PH_SEEK;
					name_pos_q <= 4'd0;
					acc_q      <= 32'd0;
					num_q      <= NUM_WS;
					neg_q      <= 1'b0;
					cmp_pos_q  <= 4'd0;
					cmp_eq_q   <= 1'b1;
					found_q    <= 1'b0;
				end else begin
					phase_q    <= phase_d;
					name_pos_q <= name_pos_d;
					acc_q      <= acc_d;
					num_q      <= num_d;
					neg_q      <= neg_d;
					cmp_pos_q  <= cmp_pos_d;
					cmp_eq_q   <= cmp_eq_d;
					found_q    <= found_d;
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'd0, out_answer_q, out_found_q, out_byte_valid_q, out_byte_q};

endmodule

// ===== sv/xave_checker.sv =====
// ----------------------------------------------------------------------------
// xave_checker
// Port-level checks on the result channel of the XML attribute value extractor.
// ----------------------------------------------------------------------------
module xave_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [xave_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input logic                                m_axis_tlast
);

	// A stalled result word keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// A word that does not end a text must carry a value byte.
	a_mid_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[8])
		else $error("non-final result without a value byte");

	// Found flag and answer appear only on the final word of a text.
	a_mid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[9] && (m_axis_tdata[41:10] == 32'd0))
		else $error("non-final result carries found or answer");

	// Without the valid flag the value byte is zero.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[8] |-> (m_axis_tdata[7:0] == 8'd0))
		else $error("value byte set without its valid flag");

endmodule

bind xml_attribute_value_extractor xave_checker u_xave_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== sim/xml_attribute_value_extractor_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xml_attribute_value_extractor_test
// Self-checking bench for the XML attribute value extractor.
// ----------------------------------------------------------------------------
// Text bytes go in as a stream of words with bursts and gaps, results are
// taken out with an irregular ready pattern. A tracker class follows the
// name search, value collection, number and comparison rules byte by byte
// and checks every result word field by field. The run opens with a few
// hand-made texts and then works through sixteen register settings (all
// four result modes, short, long and oversized lengths) with generated
// texts: mostly well-formed attribute lists, plus cut-off texts and noise.
// ----------------------------------------------------------------------------
module xml_attribute_value_extractor_test;

	typedef enum logic [2:0] {
		SCAN_SEEK,
		SCAN_NAME,
		SCAN_QUOTE,
		SCAN_VALUE,
		SCAN_DONE
	} scan_t;

	typedef enum logic [1:0] {
		NUM_LEAD,
		NUM_DIGITS,
		NUM_STOP
	} number_t;

	typedef struct {
		logic [7:0]  value;
		logic        value_ok;
		logic        last;
		logic        hit;
		logic [31:0] answer;
	} extract_word_t;

	class attr_value_tracker;
		logic [63:0]   name_chars = '0;
		logic [3:0]    name_len   = 4'd1;
		logic [1:0]    mode       = xave_pkg::MODE_BYTES;
		logic [63:0]   ref_chars  = '0;
		logic [3:0]    ref_len    = 4'd0;
		scan_t         scan       = SCAN_SEEK;
		int            name_pos;
		logic [31:0]   magnitude  = '0;
		number_t       num_state  = NUM_LEAD;
		bit            minus;
		int            cmp_pos;
		bit            cmp_ok     = 1'b1;
		bit            attr_hit;
		extract_word_t pending_values[$];
		int            errors;
		int            words_seen;

		function void set_reg(logic [xave_pkg::CFG_INDEX_W-1:0] idx,
				logic [xave_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				xave_pkg::REG_ATTR_NAME:     name_chars = d;
				xave_pkg::REG_ATTR_NAME_LEN: name_len = d[3:0];
				xave_pkg::REG_RESULT_MODE:   mode = d[1:0];
				xave_pkg::REG_MATCH_TEXT:    ref_chars = d;
				xave_pkg::REG_MATCH_LEN:     ref_len = d[3:0];
				default: ;
			endcase
		endfunction

		function int name_span();
			return int'((name_len > xave_pkg::NAME_CHARS) ? xave_pkg::NAME_CHARS : name_len);
		endfunction

		function int ref_span();
			if (mode == xave_pkg::MODE_TRUE)
				return int'(xave_pkg::TRUE_LEN);
			return int'((ref_len > xave_pkg::MATCH_CHARS) ? xave_pkg::MATCH_CHARS : ref_len);
		endfunction

		function logic [7:0] ref_char(int pos);
			if (mode == xave_pkg::MODE_TRUE)
				return xave_pkg::TRUE_TEXT[8*(pos%4) +: 8];
			return ref_chars[8*(pos%8) +: 8];
		endfunction

		function void take_number(logic [7:0] b);
			logic [63:0] wide;
			if (num_state == NUM_LEAD) begin
				if (b == xave_pkg::CHR_SPACE ||
					(b >= xave_pkg::CHR_TAB && b <= xave_pkg::CHR_CR))
					return;
				if (b == xave_pkg::CHR_PLUS || b == xave_pkg::CHR_MINUS) begin
					minus = (b == xave_pkg::CHR_MINUS);
					num_state = NUM_DIGITS;
					return;
				end
				num_state = NUM_DIGITS;
			end
			if (num_state == NUM_DIGITS) begin
				if (b >= xave_pkg::CHR_ZERO && b <= xave_pkg::CHR_NINE) begin
					wide = {32'd0, magnitude} * 64'd10 + {56'd0, b - xave_pkg::CHR_ZERO};
					magnitude = (wide > {32'd0, xave_pkg::MAG_LIMIT}) ?
						xave_pkg::MAG_LIMIT : wide[31:0];
				end else begin
					num_state = NUM_STOP;
				end
			end
		endfunction

		function void take_compare(logic [7:0] b);
			if (cmp_pos < ref_span() && b == ref_char(cmp_pos))
				cmp_pos++;
			else
				cmp_ok = 1'b0;
		endfunction

		function logic [31:0] final_answer();
			if (!attr_hit)
				return 32'd0;
			if (mode == xave_pkg::MODE_INTEGER) begin
				if (minus)
					return 32'd0 - magnitude;
				return (magnitude > xave_pkg::POS_LIMIT) ? xave_pkg::POS_LIMIT : magnitude;
			end
			if (mode == xave_pkg::MODE_TRUE || mode == xave_pkg::MODE_MATCH)
				return (cmp_ok && cmp_pos == ref_span()) ? 32'd1 : 32'd0;
			return 32'd0;
		endfunction

		function void take_byte(logic [7:0] b, logic tl);
			extract_word_t w;
			logic          ends;
			logic          emit;
			ends = tl || (b == 8'h00);
			emit = 1'b0;
			if (b != 8'h00) begin
				case (scan)
					SCAN_SEEK: begin
						if (b == xave_pkg::CHR_SPACE) begin
							scan = SCAN_NAME;
							name_pos = 0;
						end
					end
					SCAN_NAME: begin
						if (name_pos < name_span() && b == name_chars[8*name_pos +: 8]) begin
							name_pos++;
						end else if (name_pos >= name_span() && b == xave_pkg::CHR_EQUAL) begin
							attr_hit = 1'b1;
							scan = SCAN_QUOTE;
						end else if (b == xave_pkg::CHR_SPACE) begin
							name_pos = 0;
						end else begin
							scan = SCAN_SEEK;
							name_pos = 0;
						end
					end
					SCAN_QUOTE: scan = SCAN_VALUE;
					SCAN_VALUE: begin
						if (b == xave_pkg::CHR_QUOTE) begin
							scan = SCAN_DONE;
						end else begin
							take_number(b);
							take_compare(b);
							emit = (mode == xave_pkg::MODE_BYTES);
						end
					end
					default: ;
				endcase
			end
			if (ends || emit) begin
				w.value    = emit ? b : 8'h00;
				w.value_ok = emit;
				w.last     = ends;
				w.hit      = ends && attr_hit;
				w.answer   = ends ? final_answer() : 32'd0;
				pending_values.push_back(w);
			end
			if (ends) begin
				scan = SCAN_SEEK;
				name_pos = 0;
				magnitude = 32'd0;
				num_state = NUM_LEAD;
				minus = 1'b0;
				cmp_pos = 0;
				cmp_ok = 1'b1;
				attr_hit = 1'b0;
			end
		endfunction

		task flag_mismatch(string msg);
			$display("%0t: word %0d: %s", $time, words_seen, msg);
			errors++;
		endtask

		task check_word(logic [xave_pkg::OUT_TDATA_W-1:0] d, logic tl);
			extract_word_t w;
			words_seen++;
			if (pending_values.size() == 0) begin
				flag_mismatch($sformatf("unexpected word %h last %b", d, tl));
				return;
			end
			w = pending_values.pop_front();
			if (d[7:0] !== w.value)
				flag_mismatch($sformatf("value byte %h, wanted %h", d[7:0], w.value));
			if (d[8] !== w.value_ok)
				flag_mismatch($sformatf("byte valid %b, wanted %b", d[8], w.value_ok));
			if (d[9] !== w.hit)
				flag_mismatch($sformatf("found %b, wanted %b", d[9], w.hit));
			if (d[41:10] !== w.answer)
				flag_mismatch($sformatf("answer %0d, wanted %0d",
					$signed(d[41:10]), $signed(w.answer)));
			if (tl !== w.last)
				flag_mismatch($sformatf("finished %b, wanted %b", tl, w.last));
		endtask
	endclass

	logic                             clk;
	logic                             arst_n        = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [xave_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                             s_axis_tlast  = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [xave_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             m_axis_tlast;
	logic                             cfg_we        = 1'b0;
	logic [xave_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [xave_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

	attr_value_tracker tracker;
	logic [7:0]        text_q[$];
	logic              text_closing;
	int                burst_left;
	int                bytes_sent;
	int                stall_left;
	logic [63:0]       cur_name;
	logic [3:0]        cur_name_len;
	logic [1:0]        cur_mode;
	logic [63:0]       cur_match;
	logic [3:0]        cur_match_len;
	logic [1:0]        mode_order[4] = '{xave_pkg::MODE_BYTES, xave_pkg::MODE_INTEGER,
		xave_pkg::MODE_TRUE, xave_pkg::MODE_MATCH};

	xml_attribute_value_extractor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_word(m_axis_tdata, m_axis_tlast);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
			end else if (m_axis_tready) begin
				m_axis_tready <= ($urandom_range(0, 3) == 0);
				stall_left <= $urandom_range(0, 7);
			end else begin
				m_axis_tready <= 1'b1;
				stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
					: $urandom_range(0, 20);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic tl);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= tl;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.take_byte(b, tl);
		bytes_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], (i == text_q.size() - 1) ? text_closing : 1'b0);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_values.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [xave_pkg::CFG_INDEX_W-1:0] idx,
			input logic [63:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		tracker.set_reg(idx, d);
	endtask

	task automatic program_regs(input logic [63:0] nm, input logic [3:0] nl,
			input logic [1:0] md, input logic [63:0] mt, input logic [3:0] ml);
		settle();
		write_reg(xave_pkg::REG_ATTR_NAME, nm);
		write_reg(xave_pkg::REG_ATTR_NAME_LEN, {60'd0, nl});
		write_reg(xave_pkg::REG_RESULT_MODE, {62'd0, md});
		write_reg(xave_pkg::REG_MATCH_TEXT, mt);
		write_reg(xave_pkg::REG_MATCH_LEN, {60'd0, ml});
		cfg_we <= 1'b0;
		cur_name = nm;
		cur_name_len = nl;
		cur_mode = md;
		cur_match = mt;
		cur_match_len = ml;
	endtask

	function automatic void push_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] value_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == xave_pkg::CHR_QUOTE);
		return c;
	endfunction

	function automatic void push_letters(int lo, int hi);
		repeat ($urandom_range(lo, hi))
			text_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
	endfunction

	function automatic void push_value();
		int m;
		int c;
		case (cur_mode)
			xave_pkg::MODE_BYTES: begin
				repeat ($urandom_range(0, 10))
					text_q.push_back(value_char());
			end
			xave_pkg::MODE_INTEGER: begin
				repeat ($urandom_range(0, 2)) begin
					c = $urandom_range(0, 6);
					text_q.push_back((c == 6) ? xave_pkg::CHR_SPACE :
						xave_pkg::CHR_TAB + 8'(c));
				end
				c = $urandom_range(0, 3);
				if (c == 1)
					text_q.push_back(xave_pkg::CHR_PLUS);
				else if (c == 2)
					text_q.push_back(xave_pkg::CHR_MINUS);
				case ($urandom_range(0, 5))
					0: push_str("2147483647");
					1: push_str("2147483648");
					2: repeat ($urandom_range(10, 14))
						text_q.push_back(xave_pkg::CHR_ZERO + 8'($urandom_range(0, 9)));
					default: repeat ($urandom_range(0, 4))
						text_q.push_back(xave_pkg::CHR_ZERO + 8'($urandom_range(0, 9)));
				endcase
				if ($urandom_range(0, 3) == 0)
					text_q.push_back(value_char());
			end
			xave_pkg::MODE_TRUE: begin
				case ($urandom_range(0, 4))
					0, 1: push_str("true");
					2: push_str("tru");
					3: push_str("truee");
					default: push_str("trUe");
				endcase
			end
			default: begin
				m = int'((cur_match_len > xave_pkg::MATCH_CHARS) ?
					xave_pkg::MATCH_CHARS : cur_match_len);
				c = $urandom_range(0, 4);
				if (c == 3 && m > 0)
					m--;
				for (int i = 0; i < m; i++)
					text_q.push_back(cur_match[8*i +: 8]);
				if (c == 4)
					text_q.push_back(value_char());
			end
		endcase
	endfunction

	function automatic void build_text();
		int kind;
		int span;
		int cut;
		text_q.delete();
		kind = $urandom_range(0, 9);
		span = int'((cur_name_len > xave_pkg::NAME_CHARS) ?
			xave_pkg::NAME_CHARS : cur_name_len);
		if (kind == 0) begin
			repeat ($urandom_range(1, 24))
				text_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			push_str("<");
			push_letters(1, 4);
			repeat ($urandom_range(0, 2)) begin
				text_q.push_back(xave_pkg::CHR_SPACE);
				push_letters(1, 3);
				text_q.push_back(xave_pkg::CHR_EQUAL);
				text_q.push_back(xave_pkg::CHR_QUOTE);
				push_letters(0, 3);
				text_q.push_back(xave_pkg::CHR_QUOTE);
			end
			if ($urandom_range(0, 3) == 0) begin
				text_q.push_back(xave_pkg::CHR_SPACE);
				cut = $urandom_range(0, span);
				for (int i = 0; i < cut; i++)
					text_q.push_back(cur_name[8*i +: 8]);
			end
			text_q.push_back(xave_pkg::CHR_SPACE);
			for (int i = 0; i < span; i++)
				text_q.push_back(cur_name[8*i +: 8]);
			text_q.push_back(xave_pkg::CHR_EQUAL);
			text_q.push_back(($urandom_range(0, 4) == 0) ?
				8'($urandom_range(1, 255)) : xave_pkg::CHR_QUOTE);
			push_value();
			if ($urandom_range(0, 4) != 0)
				text_q.push_back(xave_pkg::CHR_QUOTE);
			if ($urandom_range(0, 1) == 0)
				push_str(" />");
			else
				repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(1, 255)));
			if (kind == 1) begin
				cut = $urandom_range(1, text_q.size());
				while (text_q.size() > cut)
					void'(text_q.pop_back());
			end
		end
		text_closing = 1'b1;
		if ($urandom_range(0, 6) == 0) begin
			text_q.push_back(8'h00);
			text_closing = 1'($urandom_range(0, 1));
		end
	endfunction

	initial begin
		logic [63:0] nm;
		logic [63:0] mt;
		logic [3:0]  nl;
		logic [3:0]  ml;
		int          target;
		tracker = new;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_regs(64'h6469, 4'd2, xave_pkg::MODE_BYTES, {$urandom, $urandom}, 4'd0);
		text_q.delete();
		push_str(" i id=\"A");
		text_q.push_back(8'hFF);
		text_closing = 1'b1;
		send_text();
		text_q.delete();
		push_str(" id=");
		text_q.push_back(8'h00);
		text_closing = 1'b0;
		send_text();
		text_q.delete();
		text_q.push_back(8'h00);
		text_closing = 1'b1;
		send_text();
		text_q.delete();
		text_q.push_back(8'h80);
		send_text();

		for (int p = 0; p < 16; p++) begin
			nm = {$urandom, $urandom};
			for (int i = 0; i < 8; i++)
				if (nm[8*i +: 8] == 8'h00 || nm[8*i +: 8] == xave_pkg::CHR_SPACE)
					nm[8*i +: 8] = 8'h61 + 8'(i);
			if (p == 1)
				nm = '1;
			case (p)
				0: nl = 4'd1;
				1: nl = 4'd8;
				2: nl = 4'd15;
				3: nl = 4'd0;
				default: nl = (p % 5 == 0) ? 4'($urandom_range(0, 15)) :
					4'($urandom_range(1, 8));
			endcase
			mt = {$urandom, $urandom};
			ml = 4'($urandom_range(0, 8));
			if (p == 3)
				ml = 4'd8;
			if (p == 7) begin
				mt = '0;
				ml = 4'd0;
			end
			if (p == 11) begin
				mt = '1;
				ml = 4'd15;
			end
			if (p == 15)
				ml = 4'd1;
			program_regs(nm, nl, mode_order[p % 4], mt, ml);
			target = bytes_sent + 100;
			while (bytes_sent < target) begin
				build_text();
				send_text();
			end
		end

		settle();
		if (tracker.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/xave_pkg.sv
sv/xml_attribute_value_extractor.sv
sv/xave_checker.sv
sim/xml_attribute_value_extractor_test.sv
